[hdl/cnv_pkg.sv]
// ----------------------------------------------------------------------------
// cnv_pkg
// shared types, constants and the saturating accumulate step of the 3x3
// convolution filter
// ----------------------------------------------------------------------------
package cnv_pkg;

    // default number of pixels a line buffer can hold
    localparam int DEFAULT_MAX_WIDTH = 1024;

    // register field widths
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 12;
    localparam int COEF_BITS  = 24;
    localparam int CFG_IDX_BITS = 3;

    // smallest frame size the counters work with
    localparam int MIN_SIZE = 3;

    // register reset values (sobel-y kernel)
    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [COEF_BITS-1:0]  RST_COEF_LEFT    = 24'h0100FF;
    localparam logic [COEF_BITS-1:0]  RST_COEF_MID     = 24'h0200FE;
    localparam logic [COEF_BITS-1:0]  RST_COEF_RIGHT   = 24'h0100FF;

    // accumulator saturation level
    localparam logic signed [17:0] SAT_LIMIT = 18'sd255;
    localparam logic [7:0]         SAT_VALUE = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_LEFT    = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_RIGHT   = 3'd4
    } cfg_reg_t;

    // input transaction payload
    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } in_item_t;

    // output transaction payload
    typedef struct packed {
        logic [7:0]  filtered;
        logic [11:0] out_row;
        logic [9:0]  out_col;
    } out_item_t;

    // per-centre control travelling down the arithmetic stages
    typedef struct packed {
        logic        filt;
        logic [11:0] row;
        logic [9:0]  col;
    } cnv_ctrl_t;

    // one product: unsigned pixel times signed coefficient
    typedef logic signed [16:0] prod_t;

    // window: [column left/mid/right][row above/centre/below]
    typedef logic [2:0][2:0][7:0] window_t;

    // one accumulate step: the signed 8-bit accumulator plus a product,
    // clipped to 0xff when the wide sum goes above 255, else wrapped
    function automatic logic [7:0] sat_step(input logic [7:0] acc, input prod_t prod);
        logic signed [17:0] sum;
        sum = $signed({{10{acc[7]}}, acc}) + $signed({prod[16], prod});
        if (sum > SAT_LIMIT) begin
            return SAT_VALUE;
        end
        return sum[7:0];
    endfunction

endpackage

[hdl/conv3x3_saturating_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_saturating_filter
// 3x3 convolution over a raster-order grey pixel stream with a signed 8-bit
// accumulator that clips to 0xff
// ----------------------------------------------------------------------------
// usage
//   in channel: one pixel per transaction in raster order; frame_start marks
//   row 0, column 0 and restarts the position counters
//   out channel: the filtered centre one row and one column behind the input,
//   with its row and column; pixels in row 0 or column 0 give no transaction,
//   centres on the frame border come out as 0
//   cfg port: image size and three columns of signed byte coefficients,
//   written only while the block is idle
// timing
//   one pixel per clock sustained while out_ready stays high; a transaction
//   passes the line memory read, the product bank and two accumulate stages
//   in that order; the rate is set by the two-port line memories,
//   one read and one write each per cycle
// reset
//   counters at row 0, column 0, window cleared, registers at their defaults;
//   line memory contents are undefined until written, no clearing pass
// stall
//   each stage holds while the next one is full, so bubbles close up and
//   in_ready drops only once every stage holds a transaction
// ----------------------------------------------------------------------------
module conv3x3_saturating_filter #(
    parameter int MAX_WIDTH = cnv_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cnv_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cnv_pkg::out_item_t              out_data,
    input  logic                            cfg_wr_en,
    input  logic [cnv_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cnv_pkg::COEF_BITS-1:0]   cfg_data
);
    import cnv_pkg::*;

    // column index bits and a width that holds both the register and MAX_WIDTH
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WX = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;

    // configuration registers
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic [2:0][23:0]      coef_reg;

    // position counters of the next pixel
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic [IMG_H_BITS-1:0] row_reg;
    logic [IMG_H_BITS-1:0] row_next;

    // stage 1: accepted pixel while the line memories are read
    logic                  s1_valid_reg;
    logic [7:0]            s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [IMG_H_BITS-1:0] s1_row_reg;
    logic                  s2_valid_reg;
    logic                  s3_valid_reg;
    logic                  out_valid_reg;

    // handshake chain, back to front
    logic ready_out;
    logic ready_s3;
    logic ready_s2;
    logic ready_s1;
    logic accept;
    logic s1_move;

    // effective frame size
    logic [WX-1:0]         w_eff;
    logic [IMG_H_BITS-1:0] h_eff;

    // position of the accepted pixel
    logic [CW-1:0]         cur_c;
    logic [IMG_H_BITS-1:0] cur_r;

    // centre of the pixel in stage 1
    logic                  s1_emit;
    logic [IMG_H_BITS-1:0] s1_cr;
    logic [WX-1:0]         s1_cc;
    cnv_ctrl_t             s1_ctrl;

    logic [7:0] line_above;
    logic [7:0] line_mid;
    prod_t      prod [9];
    cnv_ctrl_t  s2_ctrl;

    // ------------------------------------------------------------------
    // configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            coef_reg[0] <= RST_COEF_LEFT;
            coef_reg[1] <= RST_COEF_MID;
            coef_reg[2] <= RST_COEF_RIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data[IMG_H_BITS-1:0];
                REG_COEF_LEFT:    coef_reg[0] <= cfg_data;
                REG_COEF_MID:     coef_reg[1] <= cfg_data;
                REG_COEF_RIGHT:   coef_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp the frame size into the range the counters handle
    always_comb
    begin
        w_eff = WX'(width_reg);
        if (w_eff < WX'(MIN_SIZE))
        begin
            w_eff = WX'(MIN_SIZE);
        end
        if (w_eff > WX'(MAX_WIDTH))
        begin
            w_eff = WX'(MAX_WIDTH);
        end
        h_eff = (height_reg < IMG_H_BITS'(MIN_SIZE)) ? IMG_H_BITS'(MIN_SIZE) : height_reg;
    end

    // ------------------------------------------------------------------
    // handshake: a stage takes a new transaction when empty or moving on
    // ------------------------------------------------------------------
    assign ready_out = !out_valid_reg || out_ready;
    assign ready_s3  = !s3_valid_reg || ready_out;
    assign ready_s2  = !s2_valid_reg || ready_s3;
    assign ready_s1  = !s1_valid_reg || ready_s2;
    assign in_ready  = ready_s1;
    assign accept    = in_valid && ready_s1;
    assign s1_move   = s1_valid_reg && ready_s2;

    // ------------------------------------------------------------------
    // position counters; frame_start and a shrunk size both restart them
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_c = col_reg;
        cur_r = row_reg;
        if (in_data.frame_start || (WX'(col_reg) >= w_eff))
        begin
            cur_c = '0;
        end
        if (in_data.frame_start || (row_reg >= h_eff))
        begin
            cur_r = '0;
        end
        if (WX'(cur_c) + WX'(1) >= w_eff)
        begin
            col_next = '0;
            if ({1'b0, cur_r} + 13'd1 >= {1'b0, h_eff})
            begin
                row_next = '0;
            end
            else
            begin
                row_next = cur_r + 12'd1;
            end
        end
        else
        begin
            col_next = cur_c + CW'(1);
            row_next = cur_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline valid bits; stage 2 drops pixels that give no centre
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready_s2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit;
            end
            if (ready_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= in_data.pixel;
            s1_col_reg <= cur_c;
            s1_row_reg <= cur_r;
        end
    end

    // ------------------------------------------------------------------
    // centre bookkeeping for the pixel in stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_emit      = (s1_row_reg != '0) && (s1_col_reg != '0);
        s1_cr        = s1_row_reg - 12'd1;
        s1_cc        = WX'(s1_col_reg) - WX'(1);
        s1_ctrl.row  = s1_cr;
        s1_ctrl.col  = s1_cc[9:0];
        // only interior centres clear of the last row and column are filtered
        s1_ctrl.filt = (s1_cr != '0)
                    && ({1'b0, s1_cr} + 13'd3 <= {1'b0, h_eff})
                    && (s1_cc != '0)
                    && ({1'b0, s1_cc} + (WX+1)'(3) <= {1'b0, w_eff});
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    cnv_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (cur_c),
        .wr_en    (s1_move),
        .wr_addr  (s1_col_reg),
        .wr_pixel (s1_pix_reg),
        .above    (line_above),
        .mid      (line_mid)
    );

    cnv_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (s1_move),
        .col_above (line_above),
        .col_mid   (line_mid),
        .col_pixel (s1_pix_reg),
        .coef      (coef_reg),
        .ctrl_in   (s1_ctrl),
        .prod      (prod),
        .ctrl_out  (s2_ctrl)
    );

    cnv_accum u_accum (
        .clk     (clk),
        .ld_mid  (s2_valid_reg && ready_s3),
        .ld_out  (s3_valid_reg && ready_out),
        .prod    (prod),
        .ctrl_in (s2_ctrl),
        .result  (out_data)
    );

    assign out_valid = out_valid_reg;

endmodule

[hdl/cnv_line_buf.sv]
// ----------------------------------------------------------------------------
// cnv_line_buf
// two line memories (row above and centre row) with registered reads and a
// bypass for a read and a write of the same column in one cycle
// ----------------------------------------------------------------------------
module cnv_line_buf #(
    parameter int DEPTH = cnv_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_pixel,
    output logic [7:0]    above,
    output logic [7:0]    mid
);
    import cnv_pkg::*;

    logic [7:0] above_mem [DEPTH];
    logic [7:0] mid_mem [DEPTH];

    logic [7:0] rd_above_reg;
    logic [7:0] rd_mid_reg;
    logic       byp_reg;
    logic [7:0] byp_above_reg;
    logic [7:0] byp_mid_reg;

    // the centre row moves up into the above line, the new pixel into the centre
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_addr] <= mid;
            mid_mem[wr_addr]   <= wr_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_above_reg  <= above_mem[rd_addr];
            rd_mid_reg    <= mid_mem[rd_addr];
            byp_above_reg <= mid;
            byp_mid_reg   <= wr_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign above = byp_reg ? byp_above_reg : rd_above_reg;
    assign mid   = byp_reg ? byp_mid_reg   : rd_mid_reg;

endmodule

[hdl/cnv_window.sv]
// ----------------------------------------------------------------------------
// cnv_window
// 3x3 pixel window and the registered bank of nine products
// ----------------------------------------------------------------------------
module cnv_window (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic [7:0]             col_above,
    input  logic [7:0]             col_mid,
    input  logic [7:0]             col_pixel,
    input  logic [2:0][23:0]       coef,
    input  cnv_pkg::cnv_ctrl_t     ctrl_in,
    output cnv_pkg::prod_t         prod [9],
    output cnv_pkg::cnv_ctrl_t     ctrl_out
);
    import cnv_pkg::*;

    window_t   win_reg;
    window_t   win_next;
    prod_t     prod_next [9];
    prod_t     prod_reg [9];
    cnv_ctrl_t ctrl_reg;

    always_comb
    begin
        win_next[0]    = win_reg[1];
        win_next[1]    = win_reg[2];
        win_next[2][0] = col_above;
        win_next[2][1] = col_mid;
        win_next[2][2] = col_pixel;
        for (int x = 0; x < 3; x++)
        begin
            for (int y = 0; y < 3; y++)
            begin
                prod_next[3*x+y] = prod_t'($signed({1'b0, win_next[x][y]}))
                                 * prod_t'($signed(coef[x][8*y +: 8]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prod_reg <= prod_next;
            ctrl_reg <= ctrl_in;
        end
    end

    assign prod     = prod_reg;
    assign ctrl_out = ctrl_reg;

endmodule

[hdl/cnv_accum.sv]
// ----------------------------------------------------------------------------
// cnv_accum
// saturating accumulation over the nine products in two stages, and the
// output register
// ----------------------------------------------------------------------------
module cnv_accum (
    input  logic                   clk,
    input  logic                   ld_mid,
    input  logic                   ld_out,
    input  cnv_pkg::prod_t         prod [9],
    input  cnv_pkg::cnv_ctrl_t     ctrl_in,
    output cnv_pkg::out_item_t     result
);
    import cnv_pkg::*;

    logic [7:0] acc_next;
    logic [7:0] acc_reg;
    prod_t      tail_reg [4];
    cnv_ctrl_t  ctrl_reg;
    logic [7:0] fin_next;
    out_item_t  result_reg;

    // first five terms: left column and the top of the middle column
    always_comb
    begin
        acc_next = '0;
        for (int k = 0; k < 5; k++)
        begin
            acc_next = sat_step(acc_next, prod[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_mid)
        begin
            acc_reg  <= acc_next;
            ctrl_reg <= ctrl_in;
            for (int k = 0; k < 4; k++)
            begin
                tail_reg[k] <= prod[k+5];
            end
        end
    end

    always_comb
    begin
        fin_next = acc_reg;
        for (int k = 0; k < 4; k++)
        begin
            fin_next = sat_step(fin_next, tail_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            result_reg.filtered <= ctrl_reg.filt ? fin_next : 8'd0;
            result_reg.out_row  <= ctrl_reg.row;
            result_reg.out_col  <= ctrl_reg.col;
        end
    end

    assign result = result_reg;

endmodule

[bench/conv3x3_saturating_filter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_saturating_filter_test
// self-checking bench for the 3x3 saturating convolution filter
// ----------------------------------------------------------------------------
// pixel frames of assorted sizes go in through the input channel while a
// behavioral copy of the filter predicts every emitted center; the output
// channel is compared field by field in order. both channels idle at random,
// the receiver once holds off long enough to back the pipeline up, and the
// size and coefficient registers are rewritten between frame groups
// ----------------------------------------------------------------------------
module conv3x3_saturating_filter_test;

    import cnv_pkg::*;

    localparam int MAX_W           = DEFAULT_MAX_WIDTH;
    localparam int FIRST_SPARE_REG = int'(REG_COEF_RIGHT) + 1;
    localparam int LAST_SPARE_REG  = (1 << CFG_IDX_BITS) - 1;
    localparam int RANDOM_ITEMS    = 1630;
    localparam int FRAME_CAP       = 300;   // longest frame piece queued at once
    localparam int LONG_HOLD       = 150;   // length of the one long receiver hold-off
    localparam int HOLD_BACKLOG    = 32;    // pixels still queued when it starts
    localparam int SETTLE_CYCLES   = 8;     // pipeline is four stages deep
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RUN_LIMIT_NS    = 5000000;

    // ------------------------------------------------------------------
    // block ports, the inputs all known from time zero
    // ------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    in_item_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b1;
    out_item_t               out_data;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]    cfg_data  = '0;

    // ------------------------------------------------------------------
    // filter copy: registers, line memory, window and raster position
    // ------------------------------------------------------------------
    logic [IMG_W_BITS-1:0] img_width  = RST_IMAGE_WIDTH;
    logic [IMG_H_BITS-1:0] img_height = RST_IMAGE_HEIGHT;
    logic [COEF_BITS-1:0]  coef_col [3] = '{RST_COEF_LEFT, RST_COEF_MID, RST_COEF_RIGHT};
    logic [7:0]            line_mem [2*MAX_W] = '{default: 8'h00};
    // [column left/mid/right][row above/center/below]
    logic [7:0]            win [3][3] = '{default: 8'h00};
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;

    // pixels waiting to be offered, centers waiting to come out
    in_item_t              pending_pixels[$];
    out_item_t             predicted_centers[$];

    // idling knobs, written by the stimulus process only
    int unsigned           gap_pct   = 0;
    int unsigned           stall_pct = 0;
    bit                    no_idle   = 1'b0;

    // driver and monitor bookkeeping
    int unsigned           gap_left       = 0;
    int unsigned           hold_left      = 0;
    bit                    long_hold_done = 1'b0;
    int unsigned           error_count    = 0;
    out_item_t             want;

    conv3x3_saturating_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // effective frame size after clamping
    function automatic int unsigned frame_width();
        int unsigned w;
        w = 32'(img_width);
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned frame_height();
        int unsigned h;
        h = 32'(img_height);
        if (h < MIN_SIZE) h = MIN_SIZE;
        return h;
    endfunction

    // nine multiply-accumulates, left to right outside, top to bottom inside;
    // the 8-bit signed accumulator pins to 0xff when the wide sum tops 255
    function automatic logic [7:0] kernel_sum();
        logic [7:0] acc;
        int         coef_i;
        int         sum;
        acc = 8'h00;
        for (int x = 0; x < 3; x++)
        begin
            for (int y = 0; y < 3; y++)
            begin
                coef_i = int'($signed(coef_col[x][8*y +: 8]));
                sum = int'($signed(acc)) + int'(win[x][y]) * coef_i;
                if (sum > 255)
                    acc = 8'hFF;
                else
                    acc = sum[7:0];
            end
        end
        return acc;
    endfunction

    // advance the filter copy by one accepted pixel
    task automatic step_filter(input in_item_t px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned cr;
        int unsigned cc;
        logic [7:0]  above;
        logic [7:0]  mid;
        out_item_t   res;
        w = frame_width();
        h = frame_height();
        if (px.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // a size that shrank under the counters wraps them
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;

        // two-line delay: lower half holds the previous row, upper the one before
        above = line_mem[MAX_W + c];
        mid   = line_mem[c];
        line_mem[MAX_W + c] = mid;
        line_mem[c]         = px.pixel;

        for (int y = 0; y < 3; y++)
        begin
            win[0][y] = win[1][y];
            win[1][y] = win[2][y];
        end
        win[2][0] = above;
        win[2][1] = mid;
        win[2][2] = px.pixel;

        // center trails the input by one row and one column
        if (r >= 1 && c >= 1)
        begin
            cr = r - 1;
            cc = c - 1;
            res.filtered = 8'h00;
            // border centers come out as zero
            if (cr >= 1 && cr + 3 <= h && cc >= 1 && cc + 3 <= w)
                res.filtered = kernel_sum();
            res.out_row = cr[11:0];
            res.out_col = cc[9:0];
            predicted_centers.push_back(res);
        end

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: offers queued pixels, holds each until it is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                step_filter(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    in_data  <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    // idle burst after this transaction
                    if (!no_idle && $urandom_range(0, 99) < gap_pct)
                        gap_left = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: checks every transaction, stalls the receiver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_centers.size() == 0)
                begin
                    $error("unexpected result at row %0d col %0d, filtered %0d",
                           out_data.out_row, out_data.out_col, out_data.filtered);
                    error_count++;
                end
                else
                begin
                    want = predicted_centers.pop_front();
                    if (out_data.filtered !== want.filtered)
                    begin
                        $error("filtered: expected %0d, actual %0d",
                               want.filtered, out_data.filtered);
                        error_count++;
                    end
                    if (out_data.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, actual %0d",
                               want.out_row, out_data.out_row);
                        error_count++;
                    end
                    if (out_data.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, actual %0d",
                               want.out_col, out_data.out_col);
                        error_count++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && !no_idle && predicted_centers.size() != 0
                     && pending_pixels.size() >= HOLD_BACKLOG)
            begin
                // one long hold-off while centers are being produced and the
                // sender keeps offering pixels, so every stage fills and
                // in_ready drops
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && out_ready && $urandom_range(0, 99) < stall_pct)
            begin
                hold_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register write at the next edge, mirrored into the filter copy
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_IMAGE_WIDTH:  img_width   = value[IMG_W_BITS-1:0];
            REG_IMAGE_HEIGHT: img_height  = value[IMG_H_BITS-1:0];
            REG_COEF_LEFT:    coef_col[0] = value;
            REG_COEF_MID:     coef_col[1] = value;
            REG_COEF_RIGHT:   coef_col[2] = value;
            default:          ;   // unused index, ignored
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // block is idle: nothing queued, nothing offered, nothing outstanding,
    // and a few extra cycles for centers still in the pipeline
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || predicted_centers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;   // all -1
            2:       return 24'h7F7F7F;   // largest positive
            3:       return 24'h808080;   // most negative
            4:       return RST_COEF_MID;
            default: return bits[COEF_BITS-1:0];
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 30;
        endcase
    endfunction

    // new size and coefficients; some registers keep their old value
    task automatic pick_settings(input bit wide);
        logic [31:0]          noise;
        logic [COEF_BITS-1:0] val;
        noise = $urandom();
        if (wide || $urandom_range(0, 3) != 0)
        begin
            if (wide)
                val = COEF_BITS'($urandom_range(0, 1) ? MAX_W : 2047);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       val = COEF_BITS'($urandom_range(0, MIN_SIZE));
                    1:       val = COEF_BITS'($urandom_range(13, 70));
                    default: val = COEF_BITS'($urandom_range(4, 12));
                endcase
            end
            // stray bits above the field
            if ($urandom_range(0, 3) == 0)
                val[COEF_BITS-1:IMG_W_BITS] = noise[COEF_BITS-IMG_W_BITS-1:0];
            write_reg(REG_IMAGE_WIDTH, val);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 9))
                0:       val = COEF_BITS'($urandom_range(0, MIN_SIZE));
                1:       val = COEF_BITS'((1 << IMG_H_BITS) - 1);
                default: val = COEF_BITS'($urandom_range(3, 8));
            endcase
            if ($urandom_range(0, 3) == 0)
                val[COEF_BITS-1:IMG_H_BITS] = noise[31:32-(COEF_BITS-IMG_H_BITS)];
            write_reg(REG_IMAGE_HEIGHT, val);
        end
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_LEFT, pick_coef());
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_MID, pick_coef());
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_RIGHT, pick_coef());
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_IDX_BITS'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                      pick_coef());
        end_writes();
    endtask

    // queue whole frames, now and then cut short; the first frame of a group
    // and any frame after a cut start with frame_start, others may rely on
    // the counters wrapping
    task automatic queue_frames(input int unsigned budget, inout int unsigned total);
        int unsigned full_len;
        int unsigned len;
        bit          restart;
        in_item_t    px;
        restart = 1'b1;
        while (budget > 0)
        begin
            full_len = frame_width() * frame_height();
            len = full_len;
            if (len > FRAME_CAP || $urandom_range(0, 9) == 0)
                len = $urandom_range(1, (full_len > FRAME_CAP) ? FRAME_CAP : full_len - 1);
            for (int unsigned i = 0; i < len; i++)
            begin
                px.pixel       = pick_pixel();
                px.frame_start = (i == 0) && (restart || $urandom_range(0, 4) != 0);
                pending_pixels.push_back(px);
            end
            restart = (len < full_len);
            total  += len;
            budget  = (len >= budget) ? 0 : budget - len;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned total_items;
        int unsigned group;
        int unsigned drain_wait;
        bit          leftover;
        in_item_t    px;

        total_items = 0;
        group       = 0;
        leftover    = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: smallest frame with a filtered center, all-white pixels
        // against the largest coefficients to force saturation
        write_reg(REG_IMAGE_WIDTH, 24'd4);
        write_reg(REG_IMAGE_HEIGHT, 24'd4);
        write_reg(REG_COEF_LEFT, 24'h7F7F7F);
        write_reg(REG_COEF_MID, 24'h7F7F7F);
        write_reg(REG_COEF_RIGHT, 24'h7F7F7F);
        write_reg(CFG_IDX_BITS'(FIRST_SPARE_REG), 24'hFFFFFF);
        end_writes();
        @(negedge clk);
        for (int i = 0; i < 16; i++)
        begin
            px.pixel       = 8'hFF;
            px.frame_start = (i == 0);
            pending_pixels.push_back(px);
        end
        // second frame restarted in its own second row, zero pixels between high codes
        for (int i = 0; i < 8; i++)
        begin
            px.pixel       = (i % 2 == 0) ? 8'h00 : 8'h80 + 8'(i * 16 - 1);
            px.frame_start = (i == 0) || (i == 5);
            pending_pixels.push_back(px);
        end
        wait_drained();

        // random frame groups, each under its own settings and idling mix
        while (total_items < RANDOM_ITEMS)
        begin
            group++;
            pick_settings(group == 3);
            @(negedge clk);
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            if (group == 3)
            begin
                // widest line: the column counter runs to its top and wraps
                for (int unsigned i = 0; i < frame_width() + 4; i++)
                begin
                    px.pixel       = pick_pixel();
                    px.frame_start = (i == 0);
                    pending_pixels.push_back(px);
                end
                total_items += frame_width() + 4;
            end
            else
            begin
                queue_frames($urandom_range(40, 200), total_items);
            end
            wait_drained();
        end

        // closing group at full rate on both sides
        write_reg(REG_IMAGE_WIDTH, COEF_BITS'($urandom_range(4, 9)));
        write_reg(REG_IMAGE_HEIGHT, COEF_BITS'($urandom_range(4, 8)));
        write_reg(REG_COEF_MID, pick_coef());
        end_writes();
        @(negedge clk);
        no_idle = 1'b1;
        queue_frames(100, total_items);

        drain_wait = 0;
        do
        begin
            @(negedge clk);
            drain_wait++;
        end
        while ((pending_pixels.size() != 0 || in_valid || predicted_centers.size() != 0)
               && drain_wait < DRAIN_LIMIT);
        if (predicted_centers.size() != 0)
        begin
            $error("%0d predicted centers never came out", predicted_centers.size());
            leftover = 1'b1;
        end
        // room for any stray transaction to show up
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && !leftover)
            $display("conv3x3_saturating_filter_test: done, clean");
        else
            $display("conv3x3_saturating_filter_test: done, errors");
        $finish;
    end

    // hung handshake guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("conv3x3_saturating_filter_test: done, errors");
        $finish;
    end

endmodule
